/* src/s5ch_pkg.sv */
`timescale 1ns / 1ps

package s5ch_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // result kinds
    localparam logic [1:0] RK_TX     = 2'd0;
    localparam logic [1:0] RK_ADDR   = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_CONNECTED = 3'd1;
    localparam logic [2:0] ST_BADPACKET = 3'd2;
    localparam logic [2:0] ST_SERVERERR = 3'd3;
    localparam logic [2:0] ST_BADATYP   = 3'd4;
    localparam logic [2:0] ST_BADSTATE  = 3'd5;

    // address type codes
    localparam logic [7:0] ATYP_IPV4 = 8'h01;
    localparam logic [7:0] ATYP_HOST = 8'h03;
    localparam logic [7:0] ATYP_IPV6 = 8'h04;

    localparam logic [7:0] RESERVED_BYTE = 8'h00;

    // configuration register indexes
    localparam logic [2:0] CFG_VERSION     = 3'd0;
    localparam logic [2:0] CFG_COMMAND     = 3'd1;
    localparam logic [2:0] CFG_METHOD_CNT  = 3'd2;
    localparam logic [2:0] CFG_METHOD_LIST = 3'd3;
    localparam logic [2:0] CFG_ADDR_KIND   = 3'd4;
    localparam logic [2:0] CFG_ADDR_LEN    = 3'd5;
    localparam logic [2:0] CFG_DEST_PORT   = 3'd6;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic [4:0] store_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  out_byte;
        logic [2:0]  status_code;
        logic [7:0]  reply_code;
        logic [15:0] bound_port;
        logic        last_of_run;
    } t_out_item;

    // protocol phase
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_METHODSEL,
        PH_HEADER,
        PH_HOSTLEN,
        PH_ADDRESS,
        PH_PORT,
        PH_CONNECTED,
        PH_FAILED
    } t_phase;

    // transmit run sequencer
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_GREET,
        SQ_HEAD,
        SQ_HLEN,
        SQ_ADDR,
        SQ_PHI,
        SQ_PLO
    } t_seq;

endpackage

/* src/s5ch_if.sv */
`timescale 1ns / 1ps

interface s5ch_in_if;
    import s5ch_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface s5ch_out_if;
    import s5ch_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface s5ch_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

/* src/socks5_client_handshake_top.sv */
`timescale 1ns / 1ps

// socks5 client handshake byte engine
// i_in takes items: load an address byte into the store, start a handshake,
// or hand over a byte received from the server. o_out gives result items:
// bytes to transmit, bound address bytes and status, last_of_run on the
// final result of each input item. i_cfg writes the seven setup registers; the
// user must write them only while the engine is idle, the block does not
// enforce it; i_cfg is always ready. a received byte that gives one result is
// taken back to back; its result sits in the output register in the next
// cycle. a start item gives a greeting run of 2 + method count bytes, and the
// byte that completes method selection with a good version and address kind
// gives a request run of 7 to ADDRESS_BYTES_MAX + 7 bytes, one byte per cycle
// from the sequencer; the address bytes come out of the address store, read
// ahead. no new item is taken while a run is in progress. a stalled receiver
// holds the output register and the run; input stalls too.
// reset (synchronous, active low) sets the phase idle and loads register
// defaults; the address store is not cleared and must be loaded before use.
module socks5_client_handshake_top #(
    parameter int ADDRESS_BYTES_MAX = 32,
    parameter int METHODS_MAX       = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s5ch_in_if.sink    i_in,
    s5ch_out_if.source o_out,
    s5ch_cfg_if.sink   i_cfg
);
    import s5ch_pkg::*;

    localparam int AW = $clog2(ADDRESS_BYTES_MAX);
    localparam int LW = $clog2(ADDRESS_BYTES_MAX + 1);
    localparam int CW = $clog2(METHODS_MAX + 2);

    // configuration
    logic [7:0]  r_version;
    logic [7:0]  r_command;
    logic [3:0]  r_method_cnt;
    logic [63:0] r_method_list;
    logic [2:0]  r_addr_kind;
    logic [5:0]  r_addr_len;
    logic [15:0] r_dest_port;

    // protocol state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_bcnt, n_bcnt;
    logic [7:0]  r_ral, n_ral;
    logic [15:0] r_acc, n_acc;

    // run sequencer
    t_seq        r_seq, n_seq;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;

    // address store
    logic [7:0]  r_mem [ADDRESS_BYTES_MAX];
    logic [7:0]  r_rd;
    logic        w_we;
    logic [31:0] w_widx;
    logic [AW-1:0] w_waddr;

    // output register
    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_out_free;
    logic        w_acc_in;
    logic        w_step;
    logic        d_single;
    t_out_item   d_item;
    t_seq        d_run;
    t_out_item   w_seq_item;
    logic [3:0]  w_mcnt;
    logic [LW-1:0] w_host_len;
    logic [LW-1:0] w_req_len;
    logic        w_glast;
    logic [2:0]  w_midx;
    logic [8:0]  w_bnext;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_seq == SQ_IDLE) && w_out_free;
    assign w_acc_in    = i_in.valid && i_in.ready;
    assign w_step      = (r_seq != SQ_IDLE) && w_out_free;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_mcnt = (32'(r_method_cnt) > METHODS_MAX) ? 4'(METHODS_MAX) : r_method_cnt;
    assign w_host_len = (32'(r_addr_len) > ADDRESS_BYTES_MAX) ?
                        LW'(ADDRESS_BYTES_MAX) : LW'(r_addr_len);
    assign w_glast = (5'(r_cnt) == (5'(w_mcnt) + 5'd1));
    assign w_midx  = 3'(r_cnt - CW'(2));
    assign w_bnext = {1'b0, r_bcnt} + 9'd1;
    assign w_widx  = {27'd0, i_in.data.store_index};
    assign w_waddr = w_widx[AW-1:0];

    always_comb begin
        if (8'(r_addr_kind) == ATYP_IPV4) begin
            w_req_len = LW'(4);
        end else if (8'(r_addr_kind) == ATYP_IPV6) begin
            w_req_len = LW'(16);
        end else begin
            w_req_len = w_host_len;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version     <= 8'd5;
            r_command     <= 8'd1;
            r_method_cnt  <= 4'd1;
            r_method_list <= 64'd0;
            r_addr_kind   <= 3'd1;
            r_addr_len    <= 6'd4;
            r_dest_port   <= 16'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_VERSION:     r_version     <= i_cfg.value[7:0];
                CFG_COMMAND:     r_command     <= i_cfg.value[7:0];
                CFG_METHOD_CNT:  r_method_cnt  <= i_cfg.value[3:0];
                CFG_METHOD_LIST: r_method_list <= i_cfg.value;
                CFG_ADDR_KIND:   r_addr_kind   <= i_cfg.value[2:0];
                CFG_ADDR_LEN:    r_addr_len    <= i_cfg.value[5:0];
                CFG_DEST_PORT:   r_dest_port   <= i_cfg.value[15:0];
                default: ;
            endcase
        end
    end

    // request decode and protocol phase update
    always_comb begin
        d_single = 1'b0;
        d_item   = '{result_kind: RK_STATUS, out_byte: 8'd0, status_code: ST_PROGRESS,
                     reply_code: 8'd0, bound_port: 16'd0, last_of_run: 1'b1};
        d_run    = SQ_IDLE;
        n_phase  = r_phase;
        n_bcnt   = r_bcnt;
        n_ral    = r_ral;
        n_acc    = r_acc;
        w_we     = 1'b0;
        if (w_acc_in) begin
            case (i_in.data.operation)
                OP_LOAD: begin
                    w_we = (w_widx < 32'(ADDRESS_BYTES_MAX));
                end
                OP_START: begin
                    d_run   = SQ_GREET;
                    n_phase = PH_METHODSEL;
                    n_bcnt  = 8'd0;
                    n_ral   = 8'd0;
                    n_acc   = 16'd0;
                end
                OP_RECV: begin
                    d_single = 1'b1;
                    case (r_phase)
                        PH_METHODSEL: begin
                            if (r_bcnt == 8'd0) begin
                                n_acc  = {8'd0, i_in.data.data_byte};
                                n_bcnt = 8'd1;
                            end else begin
                                n_acc  = 16'd0;
                                n_bcnt = 8'd0;
                                if (r_acc[7:0] != r_version) begin
                                    d_item.status_code = ST_BADPACKET;
                                    n_phase = PH_FAILED;
                                end else if (8'(r_addr_kind) != ATYP_IPV4 &&
                                             8'(r_addr_kind) != ATYP_IPV6 &&
                                             8'(r_addr_kind) != ATYP_HOST) begin
                                    d_item.status_code = ST_BADATYP;
                                    n_phase = PH_FAILED;
                                end else begin
                                    d_single = 1'b0;
                                    d_run    = SQ_HEAD;
                                    n_phase  = PH_HEADER;
                                end
                            end
                        end
                        PH_HEADER: begin
                            case (r_bcnt)
                                8'd0: begin
                                    n_acc  = {i_in.data.data_byte, 8'd0};
                                    n_bcnt = 8'd1;
                                end
                                8'd1: begin
                                    n_acc  = {r_acc[15:8], i_in.data.data_byte};
                                    n_bcnt = 8'd2;
                                end
                                8'd2: begin
                                    n_bcnt = 8'd3;
                                end
                                default: begin
                                    // fourth header byte closes the header
                                    n_acc  = 16'd0;
                                    n_bcnt = 8'd0;
                                    if (r_acc[15:8] != r_version) begin
                                        d_item.status_code = ST_BADPACKET;
                                        n_phase = PH_FAILED;
                                    end else if (r_acc[7:0] != 8'd0) begin
                                        d_item.status_code = ST_SERVERERR;
                                        d_item.reply_code  = r_acc[7:0];
                                        n_phase = PH_FAILED;
                                    end else if (i_in.data.data_byte == ATYP_IPV4) begin
                                        n_ral   = 8'd4;
                                        n_phase = PH_ADDRESS;
                                    end else if (i_in.data.data_byte == ATYP_IPV6) begin
                                        n_ral   = 8'd16;
                                        n_phase = PH_ADDRESS;
                                    end else if (i_in.data.data_byte == ATYP_HOST) begin
                                        n_phase = PH_HOSTLEN;
                                    end else begin
                                        d_item.status_code = ST_BADATYP;
                                        n_phase = PH_FAILED;
                                    end
                                end
                            endcase
                        end
                        PH_HOSTLEN: begin
                            n_ral   = i_in.data.data_byte;
                            n_bcnt  = 8'd0;
                            n_phase = (i_in.data.data_byte == 8'd0) ? PH_PORT : PH_ADDRESS;
                        end
                        PH_ADDRESS: begin
                            d_item.result_kind = RK_ADDR;
                            d_item.out_byte    = i_in.data.data_byte;
                            if (w_bnext >= {1'b0, r_ral}) begin
                                n_bcnt  = 8'd0;
                                n_phase = PH_PORT;
                            end else begin
                                n_bcnt = w_bnext[7:0];
                            end
                        end
                        PH_PORT: begin
                            if (r_bcnt == 8'd0) begin
                                n_acc  = {i_in.data.data_byte, 8'd0};
                                n_bcnt = 8'd1;
                            end else begin
                                n_acc   = {r_acc[15:8], i_in.data.data_byte};
                                n_bcnt  = 8'd0;
                                n_phase = PH_CONNECTED;
                                d_item.status_code = ST_CONNECTED;
                                d_item.bound_port  = {r_acc[15:8], i_in.data.data_byte};
                            end
                        end
                        default: begin
                            d_item.status_code = ST_BADSTATE;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (w_acc_in && d_run != SQ_IDLE) begin
            n_seq = d_run;
            n_cnt = '0;
            n_idx = '0;
        end else if (w_step) begin
            case (r_seq)
                SQ_GREET: begin
                    if (w_glast) begin
                        n_seq = SQ_IDLE;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                SQ_HEAD: begin
                    if (r_cnt == CW'(3)) begin
                        n_seq = (8'(r_addr_kind) == ATYP_HOST) ? SQ_HLEN : SQ_ADDR;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                SQ_HLEN: begin
                    n_seq = (w_req_len == '0) ? SQ_PHI : SQ_ADDR;
                end
                SQ_ADDR: begin
                    if (LW'(r_idx) + LW'(1) == w_req_len) begin
                        n_seq = SQ_PHI;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                SQ_PHI: n_seq = SQ_PLO;
                SQ_PLO: n_seq = SQ_IDLE;
                default: n_seq = SQ_IDLE;
            endcase
        end
    end

    // sequencer output byte
    always_comb begin
        w_seq_item = '{result_kind: RK_TX, out_byte: 8'd0, status_code: ST_PROGRESS,
                       reply_code: 8'd0, bound_port: 16'd0, last_of_run: 1'b0};
        case (r_seq)
            SQ_GREET: begin
                if (r_cnt == CW'(0)) begin
                    w_seq_item.out_byte = r_version;
                end else if (r_cnt == CW'(1)) begin
                    w_seq_item.out_byte = 8'(w_mcnt);
                end else begin
                    w_seq_item.out_byte = r_method_list[{w_midx, 3'b000} +: 8];
                end
                w_seq_item.last_of_run = w_glast;
            end
            SQ_HEAD: begin
                case (r_cnt)
                    CW'(0):  w_seq_item.out_byte = r_version;
                    CW'(1):  w_seq_item.out_byte = r_command;
                    CW'(2):  w_seq_item.out_byte = RESERVED_BYTE;
                    default: w_seq_item.out_byte = 8'(r_addr_kind);
                endcase
            end
            SQ_HLEN: w_seq_item.out_byte = 8'(w_host_len);
            SQ_ADDR: w_seq_item.out_byte = r_rd;
            SQ_PHI:  w_seq_item.out_byte = r_dest_port[15:8];
            SQ_PLO: begin
                w_seq_item.out_byte    = r_dest_port[7:0];
                w_seq_item.last_of_run = 1'b1;
            end
            default: ;
        endcase
    end

    // address store, read from the next sequencer index into a register
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_in.data.data_byte;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bcnt      <= 8'd0;
            r_ral       <= 8'd0;
            r_acc       <= 16'd0;
            r_seq       <= SQ_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bcnt  <= n_bcnt;
            r_ral   <= n_ral;
            r_acc   <= n_acc;
            r_seq   <= n_seq;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            if ((w_acc_in && d_single) || w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in && d_single) begin
            r_out <= d_item;
        end else if (w_step) begin
            r_out <= w_seq_item;
        end
    end

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq == SQ_ADDR |-> (LW'(r_idx) < w_req_len))
        else $error("address index beyond request length");

    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq != SQ_IDLE |-> (r_phase == PH_METHODSEL || r_phase == PH_HEADER))
        else $error("transmit run outside greeting or request phase");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_seq_item.last_of_run) |=> (r_seq == SQ_IDLE))
        else $error("sequencer did not stop after last byte");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_seq)))
        else $error("stalled result dropped or run advanced");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import s5ch_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_EXTRA = 8;
    localparam int PHASE_ITEMS  = 20;
    localparam int PHASE_COUNT  = 8;
    localparam int PRINT_CAP    = 50;

    logic i_clk;
    logic i_rst_n;

    s5ch_in_if  in_ch ();
    s5ch_out_if out_ch ();
    s5ch_cfg_if cfg_ch ();

    socks5_client_handshake_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // engine copy: registers
    logic [7:0]  reg_version;
    logic [7:0]  reg_command;
    logic [3:0]  reg_mcount;
    logic [63:0] reg_mlist;
    logic [2:0]  reg_akind;
    logic [5:0]  reg_alen;
    logic [15:0] reg_dport;

    // engine copy: protocol state
    t_phase      eng_phase;
    logic [7:0]  eng_store [32];
    logic [8:0]  eng_count;
    logic [7:0]  eng_rlen;
    logic [7:0]  eng_rkind;
    logic [15:0] eng_acc;

    t_in_item  requests_to_send [$];
    t_out_item results_due [$];

    int errors;
    int requests_made;
    int requests_taken;
    int results_seen;
    int connects_seen;
    int burst_left;
    int gap_left;
    logic hold_req = 1'b0;
    logic rx_hold = 1'b0;

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [2:0] st, input logic [7:0] rep,
                                        input logic [15:0] port);
        t_out_item r;
        r.result_kind = kind;
        r.out_byte    = b;
        r.status_code = st;
        r.reply_code  = rep;
        r.bound_port  = port;
        r.last_of_run = 1'b0;
        results_due.push_back(r);
    endfunction

    function automatic void push_tx(input logic [7:0] b);
        push_result(RK_TX, b, ST_PROGRESS, 8'h00, 16'h0000);
    endfunction

    function automatic void push_status(input logic [2:0] st);
        push_result(RK_STATUS, 8'h00, st, 8'h00, 16'h0000);
    endfunction

    function automatic void fail_session(input logic [2:0] st);
        push_status(st);
        eng_phase = PH_FAILED;
    endfunction

    function automatic void send_connect_request();
        int len;
        logic [7:0] kind;
        kind = {5'd0, reg_akind};
        if (kind == ATYP_IPV4) len = 4;
        else if (kind == ATYP_IPV6) len = 16;
        else if (kind == ATYP_HOST) len = (reg_alen > 32) ? 32 : int'(reg_alen);
        else begin
            fail_session(ST_BADATYP);
            return;
        end
        push_tx(reg_version);
        push_tx(reg_command);
        push_tx(RESERVED_BYTE);
        push_tx(kind);
        if (kind == ATYP_HOST)
            push_tx(8'(len));
        for (int i = 0; i < len; i++)
            push_tx(eng_store[i]);
        push_tx(reg_dport[15:8]);
        push_tx(reg_dport[7:0]);
        eng_phase = PH_HEADER;
        eng_count = '0;
        eng_acc   = '0;
    endfunction

    function automatic void close_reply_header();
        logic [7:0] ver;
        logic [7:0] rep;
        ver = eng_acc[15:8];
        rep = eng_acc[7:0];
        eng_acc   = '0;
        eng_count = '0;
        if (ver != reg_version) begin
            fail_session(ST_BADPACKET);
            return;
        end
        if (rep != 8'h00) begin
            push_result(RK_STATUS, 8'h00, ST_SERVERERR, rep, 16'h0000);
            eng_phase = PH_FAILED;
            return;
        end
        if (eng_rkind == ATYP_IPV4) begin
            eng_rlen  = 8'd4;
            eng_phase = PH_ADDRESS;
        end else if (eng_rkind == ATYP_IPV6) begin
            eng_rlen  = 8'd16;
            eng_phase = PH_ADDRESS;
        end else if (eng_rkind == ATYP_HOST) begin
            eng_phase = PH_HOSTLEN;
        end else begin
            fail_session(ST_BADATYP);
            return;
        end
        push_status(ST_PROGRESS);
    endfunction

    function automatic void take_server_byte(input logic [7:0] b);
        case (eng_phase)
            PH_METHODSEL: begin
                if (eng_count == 0) begin
                    eng_acc   = {8'h00, b};
                    eng_count = 9'd1;
                    push_status(ST_PROGRESS);
                end else begin
                    logic [7:0] ver;
                    ver = eng_acc[7:0];
                    eng_acc   = '0;
                    eng_count = '0;
                    if (ver != reg_version) fail_session(ST_BADPACKET);
                    else send_connect_request();
                end
            end
            PH_HEADER: begin
                if (eng_count == 0) eng_acc = {b, 8'h00};
                else if (eng_count == 1) eng_acc[7:0] = b;
                else if (eng_count == 3) eng_rkind = b;
                if (eng_count >= 3) begin
                    close_reply_header();
                end else begin
                    eng_count = eng_count + 9'd1;
                    push_status(ST_PROGRESS);
                end
            end
            PH_HOSTLEN: begin
                eng_rlen  = b;
                eng_count = '0;
                eng_phase = (b == 8'h00) ? PH_PORT : PH_ADDRESS;
                push_status(ST_PROGRESS);
            end
            PH_ADDRESS: begin
                push_result(RK_ADDR, b, ST_PROGRESS, 8'h00, 16'h0000);
                eng_count = eng_count + 9'd1;
                if (eng_count >= {1'b0, eng_rlen}) begin
                    eng_count = '0;
                    eng_phase = PH_PORT;
                end
            end
            PH_PORT: begin
                if (eng_count == 0) begin
                    eng_acc   = {b, 8'h00};
                    eng_count = 9'd1;
                    push_status(ST_PROGRESS);
                end else begin
                    eng_acc[7:0] = b;
                    eng_count = '0;
                    eng_phase = PH_CONNECTED;
                    push_result(RK_STATUS, 8'h00, ST_CONNECTED, 8'h00, eng_acc);
                end
            end
            default: push_status(ST_BADSTATE);
        endcase
    endfunction

    function automatic void advance_engine(input t_in_item it);
        int first;
        int cnt;
        first = results_due.size();
        case (it.operation)
            OP_LOAD: eng_store[it.store_index] = it.data_byte;
            OP_START: begin
                cnt = (reg_mcount > 8) ? 8 : int'(reg_mcount);
                push_tx(reg_version);
                push_tx(8'(cnt));
                for (int i = 0; i < cnt; i++)
                    push_tx(reg_mlist[8*i +: 8]);
                eng_phase = PH_METHODSEL;
                eng_count = '0;
                eng_rlen  = '0;
                eng_rkind = '0;
                eng_acc   = '0;
            end
            OP_RECV: take_server_byte(it.data_byte);
            default: ;
        endcase
        if (results_due.size() > first)
            results_due[results_due.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void push_item(input logic [1:0] op, input logic [7:0] b,
                                      input logic [4:0] idx);
        t_in_item it;
        it.operation   = op;
        it.data_byte   = b;
        it.store_index = idx;
        requests_to_send.push_back(it);
        if (op != OP_NOP)
            requests_made++;
    endfunction

    function automatic void push_server(input logic [7:0] b);
        push_item(OP_RECV, b, 5'($urandom_range(0, 31)));
    endfunction

    // one client session, mostly well formed, sometimes cut short or corrupted
    function automatic void make_session();
        int flavor;
        int r;
        int n_addr;
        logic [7:0] v;
        logic [7:0] atyp;
        logic [7:0] hlen;
        flavor = $urandom_range(0, 99);
        push_item(OP_START, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        if (flavor < 4) return;
        v = reg_version;
        if (flavor < 10) v = v ^ 8'($urandom_range(1, 255));
        push_server(v);
        push_server(8'($urandom_range(0, 255)));
        if (flavor < 14) return;
        v = reg_version;
        if ($urandom_range(0, 19) == 0) v = v ^ 8'($urandom_range(1, 255));
        push_server(v);
        push_server(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        push_server(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 19);
        if (r < 7) atyp = ATYP_IPV4;
        else if (r < 13) atyp = ATYP_IPV6;
        else if (r < 18) atyp = ATYP_HOST;
        else atyp = 8'($urandom_range(0, 255));
        push_server(atyp);
        if (atyp == ATYP_IPV4) n_addr = 4;
        else if (atyp == ATYP_IPV6) n_addr = 16;
        else if (atyp == ATYP_HOST) begin
            hlen = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(100, 255))
                                                 : 8'($urandom_range(0, 12));
            push_server(hlen);
            n_addr = int'(hlen);
        end else n_addr = 0;
        if (flavor < 20) n_addr = $urandom_range(0, n_addr);
        for (int i = 0; i < n_addr; i++)
            push_server(8'($urandom_range(0, 255)));
        if (flavor < 20) return;
        push_server(8'($urandom_range(0, 255)));
        push_server(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            push_server(8'($urandom_range(0, 255)));
    endfunction

    function automatic void make_noise();
        case ($urandom_range(0, 9))
            0: push_item(OP_LOAD, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            1: push_server(8'($urandom_range(0, 255)));
            2: push_item(OP_NOP, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            default: ;
        endcase
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.value <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_VERSION:     reg_version = value[7:0];
            CFG_COMMAND:     reg_command = value[7:0];
            CFG_METHOD_CNT:  reg_mcount  = value[3:0];
            CFG_METHOD_LIST: reg_mlist   = value;
            CFG_ADDR_KIND:   reg_akind   = value[2:0];
            CFG_ADDR_LEN:    reg_alen    = value[5:0];
            CFG_DEST_PORT:   reg_dport   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained(input int extra);
        while (requests_to_send.size() > 0 || in_ch.valid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int p);
        logic [7:0]  v;
        logic [7:0]  c;
        logic [3:0]  mc;
        logic [63:0] ml;
        logic [2:0]  ak;
        logic [5:0]  al;
        logic [15:0] dp;
        logic [2:0]  odd_kinds [5];
        odd_kinds = '{3'd0, 3'd2, 3'd5, 3'd6, 3'd7};
        v  = 8'($urandom_range(0, 255));
        c  = 8'($urandom_range(0, 255));
        mc = 4'($urandom_range(0, 15));
        ml = {$urandom, $urandom};
        ak = 3'($urandom_range(0, 7));
        al = 6'($urandom_range(0, 63));
        dp = 16'($urandom_range(0, 65535));
        case (p)
            0: begin v = 8'd5; c = 8'd1; mc = 4'd3; ak = 3'(ATYP_IPV4); al = 6'd4; end
            1: begin
                v = 8'hFF; c = 8'hFF; mc = 4'd8; ml = '1;
                ak = 3'(ATYP_IPV6); al = 6'd32; dp = 16'hFFFF;
            end
            2: begin
                v = 8'h00; c = 8'h00; mc = 4'd0; ml = '0;
                ak = 3'(ATYP_HOST); al = 6'd63; dp = 16'h0000;
            end
            3: begin v = 8'd5; c = 8'd1; mc = 4'd15; ak = 3'(ATYP_HOST); end
            4: ak = odd_kinds[$urandom_range(0, 4)];
            5: begin v = 8'd5; c = 8'd2; end
            6: begin v = 8'd5; c = 8'd3; mc = 4'd2; ak = 3'(ATYP_IPV6); al = 6'd16; end
            default: begin
                c  = 8'd1;
                ak = $urandom_range(0, 1) ? 3'(ATYP_IPV4) : 3'(ATYP_HOST);
                al = 6'($urandom_range(0, 20));
            end
        endcase
        write_register(CFG_VERSION, {56'd0, v});
        write_register(CFG_COMMAND, {56'd0, c});
        write_register(CFG_METHOD_CNT, {60'd0, mc});
        write_register(CFG_METHOD_LIST, ml);
        write_register(CFG_ADDR_KIND, {61'd0, ak});
        write_register(CFG_ADDR_LEN, {58'd0, al});
        write_register(CFG_DEST_PORT, {48'd0, dp});
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("socks5_client_handshake_top regression: fail");
        $finish;
    end

    // long receiver hold-off, counted here so the block backs up into its input
    initial begin : rx_hold_proc
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
            wait (!hold_req);
        end
    end

    always @(posedge i_clk) begin : in_driver
        logic     nv;
        t_in_item nd;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            nv = 1'b0;
            nd = in_ch.data;
            if (in_ch.valid)
                void'(requests_to_send.pop_front());
            if (gap_left > 0) begin
                gap_left--;
            end else if (requests_to_send.size() > 0) begin
                nv = 1'b1;
                nd = requests_to_send[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        9:          gap_left = $urandom_range(15, 40);
                        default:    gap_left = $urandom_range(1, 6);
                    endcase
                end
            end
            in_ch.valid <= nv;
            in_ch.data  <= nd;
        end
    end

    always @(posedge i_clk) begin : rx_pacer
        logic [15:0] pat;
        int          pattern_left;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            pattern_left = 0;
            pat = '1;
        end else if (rx_hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = '1;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom) | 16'($urandom);
                    default: pat = 16'($urandom) & 16'($urandom);
                endcase
                pattern_left = $urandom_range(16, 200);
            end else begin
                pat = {pat[0], pat[15:1]};
                pattern_left--;
            end
            out_ch.ready <= pat[0];
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item got;
        t_out_item want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                advance_engine(in_ch.data);
                requests_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen++;
                if (got.result_kind == RK_STATUS && got.status_code == ST_CONNECTED)
                    connects_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = results_due.pop_front();
                    check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
                    check_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
                    check_field("status_code", 16'(got.status_code), 16'(want.status_code));
                    check_field("reply_code", 16'(got.reply_code), 16'(want.reply_code));
                    check_field("bound_port", got.bound_port, want.bound_port);
                    check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
                end
            end
        end
    end

    initial begin : stimulus
        int goal;
        bit paused;
        errors = 0;
        requests_made  = 0;
        requests_taken = 0;
        results_seen   = 0;
        connects_seen  = 0;
        paused = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.value   = '0;
        // register defaults and state after reset
        reg_version = 8'd5;
        reg_command = 8'd1;
        reg_mcount  = 4'd1;
        reg_mlist   = '0;
        reg_akind   = 3'(ATYP_IPV4);
        reg_alen    = 6'd4;
        reg_dport   = '0;
        eng_phase   = PH_IDLE;
        eng_count   = '0;
        eng_rlen    = '0;
        eng_rkind   = '0;
        eng_acc     = '0;
        foreach (eng_store[i]) eng_store[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // fill the whole address store before any request reads it
        for (int i = 0; i < 32; i++)
            push_item(OP_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF
                               : 8'($urandom_range(0, 255)), 5'(i));
        push_server(8'hA5);                         // byte while idle
        push_item(OP_NOP, 8'h3C, 5'd7);             // unused operation
        push_item(OP_START, 8'h00, 5'd0);
        push_server(8'd5);
        push_server(8'd0);                          // completes method selection
        push_server(8'd5);
        push_server(8'd0);
        push_server(8'h00);
        push_server(ATYP_IPV4);
        push_server(8'h00);
        push_server(8'hFF);
        push_server(8'h12);
        push_server(8'h34);
        push_server(8'hFF);
        push_server(8'hFF);
        push_server(8'h00);                         // after connected
        push_item(OP_START, 8'hFF, 5'd31);
        push_server(8'd5);
        push_item(OP_START, 8'h55, 5'd3);           // restart mid-session
        push_server(8'd5);
        push_server(8'd2);
        push_server(8'd5);
        push_server(8'h5A);                         // server error reply
        push_server(8'h00);
        push_server(ATYP_IPV4);
        push_item(OP_START, 8'hAA, 5'd9);
        push_server(8'd4);                          // wrong version
        push_server(8'd0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained(SETTLE_EXTRA);
            apply_setting(p);
            goal = requests_made + PHASE_ITEMS;
            if (p == 2 || p == 6) hold_req = 1'b1;
            while (requests_made < goal) begin
                if (p == 4 && !paused && requests_made >= goal - PHASE_ITEMS / 2) begin
                    // sender waits for every outstanding result
                    wait_drained(0);
                    paused = 1'b1;
                end
                make_noise();
                make_session();
            end
            if (hold_req) begin
                wait_drained(0);
                hold_req = 1'b0;
            end
        end

        wait_drained(SETTLE_EXTRA);
        repeat (20) @(posedge i_clk);
        $display("run covered %0d requests over %0d register settings", requests_taken,
                 PHASE_COUNT + 1);
        $display("checked %0d results, %0d sessions reached connected", results_seen,
                 connects_seen);
        if (errors == 0) begin
            $display("socks5_client_handshake_top regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("socks5_client_handshake_top regression: fail");
        end
        $finish;
    end

endmodule
